// File: hdl/wdss_pkg.sv
// Shared types and constants for the weighted decision stump search block.
// No dependencies; compiled first.
package wdss_pkg;

   // datapath width of the shared adder: holds signed sums from -2^34 to 2^34-1
   localparam int ALU_W = 35;
   localparam int SUM_W = 32;
   localparam int DIFF_W = 33;
   localparam int TOT_W = 34;
   localparam int QUO_W = 16;
   localparam int FRAC_W = 17;
   localparam int IDX_OUT_W = 12;
   localparam int FV_W = 32;
   localparam int WGT_W = 20;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
   localparam logic [SUM_W-1:0] SUM_MAX = 32'hFFFF_FFFF;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_ADD  = 12'b0000_0000_0010,
      S_DIFF = 12'b0000_0000_0100,
      S_CMIN = 12'b0000_0000_1000,
      S_CMAX = 12'b0000_0001_0000,
      S_ERRP = 12'b0000_0010_0000,
      S_ERRN = 12'b0000_0100_0000,
      S_TOT  = 12'b0000_1000_0000,
      S_SEL  = 12'b0001_0000_0000,
      S_CHK  = 12'b0010_0000_0000,
      S_DIV  = 12'b0100_0000_0000,
      S_DONE = 12'b1000_0000_0000
   } state_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type               op;
      logic signed [ALU_W-1:0]  a;
      logic signed [ALU_W-1:0]  b;
   } alu_req_type;

   typedef struct packed {
      logic signed [ALU_W-1:0]  sum;
      logic                     negative;
   } alu_rsp_type;

endpackage

// File: hdl/wdss_ifc.sv
// Valid/ready channel interfaces for sample and result words.
// Depends on nothing; compiled after wdss_pkg.
interface wdss_req_if;
   logic               valid;
   logic               ready;
   logic [19:0]        weight_scaled;
   logic               is_positive;
   logic signed [31:0] feature_value;
   logic               last_sample;

   modport source (output valid, weight_scaled, is_positive, feature_value, last_sample,
                   input ready);
   modport sink (input valid, weight_scaled, is_positive, feature_value, last_sample,
                 output ready);
endinterface

interface wdss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] threshold;
   logic               polarity_negative;
   logic [11:0]        split_index;
   logic [31:0]        weighted_error;
   logic [31:0]        total_weight;
   logic [16:0]        error_fraction;

   modport source (output valid, threshold, polarity_negative, split_index, weighted_error,
                   total_weight, error_fraction, input ready);
   modport sink (input valid, threshold, polarity_negative, split_index, weighted_error,
                 total_weight, error_fraction, output ready);
endinterface

// File: hdl/wdss_alu.sv
// Shared 35-bit signed add/subtract unit with sign flag.
// Depends on wdss_pkg.
module wdss_alu (
   input  wdss_pkg::alu_req_type alu_req,
   output wdss_pkg::alu_rsp_type alu_rsp
);
   import wdss_pkg::*;

   logic signed [ALU_W-1:0] b_eff;
   logic                    carry_in;

   always_comb begin
      b_eff    = (alu_req.op == ALU_SUB) ? ~alu_req.b : alu_req.b;
      carry_in = (alu_req.op == ALU_SUB);
      alu_rsp.sum      = alu_req.a + b_eff + {{(ALU_W-1){1'b0}}, carry_in};
      alu_rsp.negative = alu_rsp.sum[ALU_W-1];
   end
endmodule

// File: hdl/weighted_decision_stump_search_top.sv
// Weighted decision stump search: top level with sequencer and datapath registers.
// Depends on wdss_pkg, wdss_req_if/wdss_rsp_if and wdss_alu.
//
// Sorted samples of one feature arrive one word at a time; the block keeps
// saturating positive and negative weight sums and the best split for each
// polarity, and on the word flagged last it returns threshold, polarity, split
// index, weighted error, total weight and the Q1.16 error fraction. All work
// goes through one shared 35-bit adder: an ordinary sample passes through the
// states accept, weight add, difference, minimum compare and maximum compare. The
// last sample then adds the error, total, selection and check steps, a restoring
// division (one quotient bit per cycle, skipped when the total is zero or the
// error equals the total) and a hand-over that loads the result register once
// it is free. Input is not taken while a sample is in progress; a finished
// result waits in its own register, so the next set may start meanwhile.
module weighted_decision_stump_search_top #(
   parameter int MAX_SAMPLES = 4096
) (
   input logic        clock,
   input logic        reset,
   wdss_req_if.sink   req_if,
   wdss_rsp_if.source rsp_if
);
   import wdss_pkg::*;

   localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

   state_type state_ff, state_in;

   logic [WGT_W-1:0]         wgt_ff, wgt_in;
   logic                     lbl_ff, lbl_in;
   logic signed [FV_W-1:0]   fv_ff, fv_in;
   logic                     last_ff, last_in;

   logic [SUM_W-1:0]         pos_ff, pos_in;
   logic [SUM_W-1:0]         neg_ff, neg_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [DIFF_W-1:0] min_ff, min_in;
   logic signed [DIFF_W-1:0] max_ff, max_in;
   logic [IDX_W-1:0]         min_idx_ff, min_idx_in;
   logic [IDX_W-1:0]         max_idx_ff, max_idx_in;
   logic signed [FV_W-1:0]   min_val_ff, min_val_in;
   logic signed [FV_W-1:0]   max_val_ff, max_val_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   logic signed [ALU_W-1:0]  errp_ff, errp_in;
   logic signed [ALU_W-1:0]  errn_ff, errn_in;
   logic [TOT_W-1:0]         tot_ff, tot_in;
   logic [TOT_W-1:0]         err_ff, err_in;
   logic signed [FV_W-1:0]   thr_ff, thr_in;
   logic                     pol_ff, pol_in;
   logic [IDX_W-1:0]         sel_idx_ff, sel_idx_in;
   logic [TOT_W-1:0]         rem_ff, rem_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [3:0]               div_cnt_ff, div_cnt_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [FV_W-1:0]   rsp_thr_ff, rsp_thr_in;
   logic                     rsp_pol_ff, rsp_pol_in;
   logic [IDX_OUT_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [SUM_W-1:0]         rsp_err_ff, rsp_err_in;
   logic [SUM_W-1:0]         rsp_tot_ff, rsp_tot_in;
   logic [FRAC_W-1:0]        rsp_frac_ff, rsp_frac_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic                     req_fire;
   logic                     first;
   logic [IDX_W-1:0]         cur_idx;
   logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
   logic [SUM_W-1:0]         acc_sel;

   wdss_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign first        = (cnt_ff == '0);
   assign cur_idx      = (cnt_ff < CNT_MAX) ? cnt_ff[IDX_W-1:0] : IDX_LAST;
   assign acc_sel      = lbl_ff ? pos_ff : neg_ff;
   assign idx_ext      = {{IDX_OUT_W{1'b0}}, sel_idx_ff};

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.threshold         = rsp_thr_ff;
   assign rsp_if.polarity_negative = rsp_pol_ff;
   assign rsp_if.split_index       = rsp_idx_ff;
   assign rsp_if.weighted_error    = rsp_err_ff;
   assign rsp_if.total_weight      = rsp_tot_ff;
   assign rsp_if.error_fraction    = rsp_frac_ff;

   // operand selection for the shared adder
   always_comb begin
      alu_req.op = ALU_SUB;
      alu_req.a  = '0;
      alu_req.b  = '0;
      unique case (state_ff)
         S_ADD: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {3'b0, acc_sel};
            alu_req.b  = {{(ALU_W-WGT_W){1'b0}}, wgt_ff};
         end
         S_DIFF: begin
            alu_req.a = {3'b0, pos_ff};
            alu_req.b = {3'b0, neg_ff};
         end
         S_CMIN: begin
            alu_req.a = {{2{diff_ff[DIFF_W-1]}}, diff_ff};
            alu_req.b = {{2{min_ff[DIFF_W-1]}}, min_ff};
         end
         S_CMAX: begin
            alu_req.a = {{2{max_ff[DIFF_W-1]}}, max_ff};
            alu_req.b = {{2{diff_ff[DIFF_W-1]}}, diff_ff};
         end
         S_ERRP: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {3'b0, neg_ff};
            alu_req.b  = {{2{min_ff[DIFF_W-1]}}, min_ff};
         end
         S_ERRN: begin
            alu_req.a = {3'b0, pos_ff};
            alu_req.b = {{2{max_ff[DIFF_W-1]}}, max_ff};
         end
         S_TOT: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {3'b0, pos_ff};
            alu_req.b  = {3'b0, neg_ff};
         end
         S_SEL: begin
            alu_req.a = errp_ff;
            alu_req.b = errn_ff;
         end
         S_CHK: begin
            alu_req.a = {1'b0, err_ff};
            alu_req.b = {1'b0, tot_ff};
         end
         S_DIV: begin
            alu_req.a = {rem_ff, 1'b0};
            alu_req.b = {1'b0, tot_ff};
         end
         S_IDLE, S_DONE: begin
            alu_req.op = ALU_SUB;
         end
         default: begin
            alu_req.op = ALU_SUB;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      wgt_in       = wgt_ff;
      lbl_in       = lbl_ff;
      fv_in        = fv_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      diff_in      = diff_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      min_idx_in   = min_idx_ff;
      max_idx_in   = max_idx_ff;
      min_val_in   = min_val_ff;
      max_val_in   = max_val_ff;
      cnt_in       = cnt_ff;
      errp_in      = errp_ff;
      errn_in      = errn_ff;
      tot_in       = tot_ff;
      err_in       = err_ff;
      thr_in       = thr_ff;
      pol_in       = pol_ff;
      sel_idx_in   = sel_idx_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      frac_in      = frac_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_thr_in   = rsp_thr_ff;
      rsp_pol_in   = rsp_pol_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_frac_in  = rsp_frac_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               wgt_in   = req_if.weight_scaled;
               lbl_in   = req_if.is_positive;
               fv_in    = req_if.feature_value;
               last_in  = req_if.last_sample;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            // saturate the running sum at all ones
            if (lbl_ff) begin
               pos_in = alu_rsp.sum[SUM_W] ? SUM_MAX : alu_rsp.sum[SUM_W-1:0];
            end else begin
               neg_in = alu_rsp.sum[SUM_W] ? SUM_MAX : alu_rsp.sum[SUM_W-1:0];
            end
            state_in = S_DIFF;
         end
         S_DIFF: begin
            diff_in  = alu_rsp.sum[DIFF_W-1:0];
            state_in = S_CMIN;
         end
         S_CMIN: begin
            if (first || alu_rsp.negative) begin
               min_in     = diff_ff;
               min_idx_in = cur_idx;
               min_val_in = fv_ff;
            end
            state_in = S_CMAX;
         end
         S_CMAX: begin
            if (first || alu_rsp.negative) begin
               max_in     = diff_ff;
               max_idx_in = cur_idx;
               max_val_in = fv_ff;
            end
            if (cnt_ff < CNT_MAX) begin
               cnt_in = cnt_ff + 1'b1;
            end
            state_in = last_ff ? S_ERRP : S_IDLE;
         end
         S_ERRP: begin
            errp_in  = alu_rsp.sum;
            state_in = S_ERRN;
         end
         S_ERRN: begin
            errn_in  = alu_rsp.sum;
            state_in = S_TOT;
         end
         S_TOT: begin
            tot_in   = alu_rsp.sum[TOT_W-1:0];
            state_in = S_SEL;
         end
         S_SEL: begin
            // direction +1 only on a strictly smaller error
            if (alu_rsp.negative) begin
               err_in     = errp_ff[TOT_W-1:0];
               thr_in     = min_val_ff;
               pol_in     = 1'b0;
               sel_idx_in = min_idx_ff;
            end else begin
               err_in     = errn_ff[TOT_W-1:0];
               thr_in     = max_val_ff;
               pol_in     = 1'b1;
               sel_idx_in = max_idx_ff;
            end
            state_in = S_CHK;
         end
         S_CHK: begin
            rem_in     = err_ff;
            quo_in     = '0;
            div_cnt_in = 4'hF;
            if (tot_ff == '0) begin
               frac_in  = '0;
               state_in = S_DONE;
            end else if (!alu_rsp.negative) begin
               frac_in  = FRAC_ONE;
               state_in = S_DONE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (alu_rsp.negative) begin
               rem_in = {rem_ff[TOT_W-2:0], 1'b0};
            end else begin
               rem_in = alu_rsp.sum[TOT_W-1:0];
            end
            quo_in     = {quo_ff[QUO_W-2:0], ~alu_rsp.negative};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               frac_in  = {1'b0, quo_ff[QUO_W-2:0], ~alu_rsp.negative};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hand over once the result register is free, then start a new set
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_thr_in   = thr_ff;
               rsp_pol_in   = pol_ff;
               rsp_idx_in   = idx_ext[IDX_OUT_W-1:0];
               rsp_err_in   = (err_ff[TOT_W-1:SUM_W] != '0) ? SUM_MAX : err_ff[SUM_W-1:0];
               rsp_tot_in   = (tot_ff[TOT_W-1:SUM_W] != '0) ? SUM_MAX : tot_ff[SUM_W-1:0];
               rsp_frac_in  = frac_ff;
               pos_in       = '0;
               neg_in       = '0;
               cnt_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         neg_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wgt_ff      <= wgt_in;
      lbl_ff      <= lbl_in;
      fv_ff       <= fv_in;
      last_ff     <= last_in;
      diff_ff     <= diff_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      min_idx_ff  <= min_idx_in;
      max_idx_ff  <= max_idx_in;
      min_val_ff  <= min_val_in;
      max_val_ff  <= max_val_in;
      errp_ff     <= errp_in;
      errn_ff     <= errn_in;
      tot_ff      <= tot_in;
      err_ff      <= err_in;
      thr_ff      <= thr_in;
      pol_ff      <= pol_in;
      sel_idx_ff  <= sel_idx_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      frac_ff     <= frac_in;
      rsp_thr_ff  <= rsp_thr_in;
      rsp_pol_ff  <= rsp_pol_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_frac_ff <= rsp_frac_in;
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word raised outside the hand-over state");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_frac_ff <= FRAC_ONE)
      else $error("error fraction above one");

   a_err_le_tot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_err_ff <= rsp_tot_ff)
      else $error("weighted error above total weight");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == S_DONE) && state_ff == S_IDLE) |->
         (pos_ff == '0 && neg_ff == '0 && cnt_ff == '0))
      else $error("running sums not cleared after the last sample");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < tot_ff)
      else $error("division remainder not below the divisor");

endmodule

// File: sim/tb_weighted_decision_stump_search_top.sv
// Testbench for weighted_decision_stump_search_top: streams sample sets, mostly sorted,
// predicts the chosen split of each set and checks every result word.
// Depends on wdss_pkg, wdss_req_if/wdss_rsp_if and the block under test.
module tb_weighted_decision_stump_search_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wdss_pkg::*;

   localparam int SAMPLE_CAP = 4096;
   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_WORDS = 550;
   localparam int SETTLE_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [WGT_W-1:0]       weight_scaled;
      logic                   is_positive;
      logic signed [FV_W-1:0] feature_value;
      logic                   last_sample;
      logic                   drain_first;
   } sample_word_type;

   typedef struct packed {
      logic signed [FV_W-1:0] threshold;
      logic                   polarity_negative;
      logic [IDX_OUT_W-1:0]   split_index;
      logic [SUM_W-1:0]       weighted_error;
      logic [SUM_W-1:0]       total_weight;
      logic [FRAC_W-1:0]      error_fraction;
   } split_result_type;

   logic clock = 1'b0;
   logic reset;

   wdss_req_if req_bus ();
   wdss_rsp_if rsp_bus ();

   weighted_decision_stump_search_top #(.MAX_SAMPLES(SAMPLE_CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   sample_word_type  sample_q[$];
   split_result_type split_q[$];
   int               mismatches = 0;

   // running state of the split search
   logic [SUM_W-1:0]         pos_sum = '0;
   logic [SUM_W-1:0]         neg_sum = '0;
   logic signed [DIFF_W-1:0] min_diff = '0;
   logic signed [DIFF_W-1:0] max_diff = '0;
   logic [IDX_OUT_W-1:0]     min_idx = '0;
   logic [IDX_OUT_W-1:0]     max_idx = '0;
   logic signed [FV_W-1:0]   min_fv = '0;
   logic signed [FV_W-1:0]   max_fv = '0;
   int                       words_in_set = 0;

   function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [WGT_W-1:0] w);
      logic [SUM_W:0] s;
      s = {1'b0, a} + w;
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_out(longint v);
      return (v > longint'(SUM_MAX)) ? SUM_MAX : SUM_W'(v);
   endfunction

   task automatic predict_split(input sample_word_type s);
      logic signed [DIFF_W-1:0] d;
      logic [IDX_OUT_W-1:0]     idx;
      longint                   err_p, err_n, tot, err;
      longint unsigned          frac;
      split_result_type         r;
      if (s.is_positive) begin
         pos_sum = sat_sum(pos_sum, s.weight_scaled);
      end else begin
         neg_sum = sat_sum(neg_sum, s.weight_scaled);
      end
      d = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
      idx = (words_in_set < SAMPLE_CAP) ? IDX_OUT_W'(words_in_set) : IDX_OUT_W'(SAMPLE_CAP - 1);
      // strict compares: the first index wins a tie
      if (words_in_set == 0 || d < min_diff) begin
         min_diff = d;
         min_idx = idx;
         min_fv = s.feature_value;
      end
      if (words_in_set == 0 || d > max_diff) begin
         max_diff = d;
         max_idx = idx;
         max_fv = s.feature_value;
      end
      if (words_in_set < SAMPLE_CAP) words_in_set++;
      if (s.last_sample) begin
         err_p = longint'(neg_sum) + longint'(min_diff);
         err_n = longint'(pos_sum) - longint'(max_diff);
         tot = longint'(pos_sum) + longint'(neg_sum);
         // direction -1 takes equal errors
         if (err_p < err_n) begin
            err = err_p;
            r.threshold = min_fv;
            r.polarity_negative = 1'b0;
            r.split_index = min_idx;
         end else begin
            err = err_n;
            r.threshold = max_fv;
            r.polarity_negative = 1'b1;
            r.split_index = max_idx;
         end
         frac = (tot == 0) ? 0 : (longint'(err) << 16) / tot;
         if (frac > FRAC_ONE) frac = FRAC_ONE;
         r.weighted_error = sat_out(err);
         r.total_weight = sat_out(tot);
         r.error_fraction = FRAC_W'(frac);
         split_q.push_back(r);
         pos_sum = '0;
         neg_sum = '0;
         min_diff = '0;
         max_diff = '0;
         min_idx = '0;
         max_idx = '0;
         min_fv = '0;
         max_fv = '0;
         words_in_set = 0;
      end
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   function automatic logic [WGT_W-1:0] pick_weight(int mode);
      int m;
      m = (mode == 4) ? $urandom_range(0, 3) : mode;
      case (m)
         0: return WGT_W'($urandom_range(0, 20'hFFFFF));
         1: return WGT_W'($urandom_range(0, 15));
         2: return '0;
         default: return WGT_W'($urandom_range(20'hFFF00, 20'hFFFFF));
      endcase
   endfunction

   task automatic push_word(input logic [WGT_W-1:0] w, input logic pos,
                            input logic signed [FV_W-1:0] fv, input logic last);
      sample_word_type s;
      s.weight_scaled = w;
      s.is_positive = pos;
      s.feature_value = fv;
      s.last_sample = last;
      s.drain_first = 1'b0;
      sample_q.push_back(s);
   endtask

   task automatic push_set(input int len, input int wmode, input bit ordered,
                           input bit drain_first);
      sample_word_type s;
      longint          fv;
      int unsigned     step_max;
      int              pos_pct;
      fv = longint'(int'($urandom()));
      step_max = ($urandom_range(0, 1) == 1) ? 64 : 32'h07FF_FFFF;
      pos_pct = $urandom_range(1, 4) * 20;
      for (int k = 0; k < len; k++) begin
         s.weight_scaled = pick_weight(wmode);
         s.is_positive = ($urandom_range(0, 99) < pos_pct);
         s.feature_value = ordered ? FV_W'(fv) : FV_W'($urandom());
         s.last_sample = (k == len - 1);
         s.drain_first = drain_first && (k == 0);
         sample_q.push_back(s);
         fv += $urandom_range(0, step_max);
         if (fv > 64'sd2147483647) fv = 64'sd2147483647;
      end
   endtask

   // sender: bursts of words with random gaps
   bit word_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int gap_roll;

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !word_taken)) begin
         word_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (sample_q.size() > 0 &&
                      !(sample_q[0].drain_first && split_q.size() > 0)) begin
            req_bus.valid <= 1'b1;
            req_bus.weight_scaled <= sample_q[0].weight_scaled;
            req_bus.is_positive <= sample_q[0].is_positive;
            req_bus.feature_value <= sample_q[0].feature_value;
            req_bus.last_sample <= sample_q[0].last_sample;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_roll = $urandom_range(0, 7);
               if (gap_roll < 4) gap_left = 0;
               else if (gap_roll < 6) gap_left = $urandom_range(1, 4);
               else if (gap_roll == 6) gap_left = $urandom_range(5, 12);
               else gap_left = $urandom_range(13, 30);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: free stretches alternate with random and long stalls
   int stall_left = 0;
   int stall_roll;
   int unsigned cycle_count = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 15);
         if (cycle_count[10]) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_roll == 0) begin
            stall_left = $urandom_range(1, 40);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= (stall_roll > 5);
         end
      end
      cycle_count++;
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         predict_split(sample_q.pop_front());
         word_taken = 1'b1;
      end
   end

   split_result_type want;
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (split_q.size() == 0) begin
               $display("%0t: result word expected none actual threshold %0h error %0h",
                        $time, rsp_bus.threshold, rsp_bus.weighted_error);
               mismatches++;
            end else begin
               want = split_q.pop_front();
               check_field("threshold", want.threshold, rsp_bus.threshold);
               check_field("polarity_negative", want.polarity_negative,
                           rsp_bus.polarity_negative);
               check_field("split_index", want.split_index, rsp_bus.split_index);
               check_field("weighted_error", want.weighted_error, rsp_bus.weighted_error);
               check_field("total_weight", want.total_weight, rsp_bus.total_weight);
               check_field("error_fraction", want.error_fraction, rsp_bus.error_fraction);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      int random_words;
      int set_roll;
      int len;
      random_words = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.weight_scaled = '0;
      req_bus.is_positive = 1'b0;
      req_bus.feature_value = '0;
      req_bus.last_sample = 1'b0;
      rsp_bus.ready = 1'b0;

      // zero total weight on a single word
      push_word(20'h00000, 1'b0, 32'sh8000_0000, 1'b1);
      // single full-weight positive word
      push_word(20'hFFFFF, 1'b1, 32'sh7FFF_FFFF, 1'b1);
      // equal errors for both directions
      push_word(20'd1, 1'b0, -32'sd5, 1'b0);
      push_word(20'd2, 1'b1, 32'sd0, 1'b0);
      push_word(20'd1, 1'b0, 32'sd7, 1'b1);
      // repeated extremes of the difference, feature extremes
      push_word(20'd5, 1'b1, 32'sh8000_0000, 1'b0);
      push_word(20'd5, 1'b0, -32'sd1, 1'b0);
      push_word(20'd5, 1'b1, 32'sd0, 1'b0);
      push_word(20'd5, 1'b0, 32'sh7FFF_FFFF, 1'b1);
      // all weights zero
      push_word(20'd0, 1'b1, 32'sd10, 1'b0);
      push_word(20'd0, 1'b0, 32'sd20, 1'b0);
      push_word(20'd0, 1'b1, 32'sd30, 1'b1);
      // unsorted feature values
      push_word(20'd300, 1'b1, 32'sd1000, 1'b0);
      push_word(20'd700, 1'b0, -32'sd1000, 1'b0);
      push_word(20'hAAAAA, 1'b1, -32'sd2000, 1'b0);
      push_word(20'h55555, 1'b0, 32'sd500, 1'b1);
      // direction +1 wins
      push_word(20'd9, 1'b0, 32'sd1, 1'b0);
      push_word(20'd9, 1'b1, 32'sd2, 1'b1);

      while (random_words < RANDOM_WORDS) begin
         set_roll = $urandom_range(0, 99);
         if (set_roll < 70) len = $urandom_range(1, 10);
         else if (set_roll < 90) len = $urandom_range(11, 40);
         else len = $urandom_range(1, 6);
         // the first random set, and about one in twenty others, holds off until every result is back
         push_set(len, $urandom_range(0, 4), set_roll < 90,
                  random_words == 0 || $urandom_range(0, 19) == 0);
         random_words += len;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (sample_q.size() > 0 || split_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && split_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/wdss_pkg.sv
hdl/wdss_ifc.sv
hdl/wdss_alu.sv
hdl/weighted_decision_stump_search_top.sv
sim/tb_weighted_decision_stump_search_top.sv
